>>> rtl/id_allocator_free_stack_unit_defines.svh
// Assertion macros used by the allocator top module.
`ifndef ID_ALLOCATOR_FREE_STACK_UNIT_DEFINES_SVH
`define ID_ALLOCATOR_FREE_STACK_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check while out of reset.
`define IDALLOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every edge, reset included.
`define IDALLOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IDALLOC_ASSERT(lbl, prop, msg)
`define IDALLOC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/idalloc_pkg.sv
`default_nettype none
package idalloc_pkg;

  localparam int unsigned IdW = 8;

  typedef logic [IdW-1:0] id_t;

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage
`default_nettype wire

>>> rtl/idalloc_stack_mem.sv
`default_nettype none
module idalloc_stack_mem
  import idalloc_pkg::*;
#(
  parameter int unsigned ID_COUNT = 32,
  localparam int unsigned IdxW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output id_t                  rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire id_t             wr_data_i
);

  id_t                  mem_q [ID_COUNT];
  logic [ID_COUNT-1:0]  written_q;
  id_t                  rd_data_q;
  logic                 rd_written_q;
  logic [IdxW-1:0]      rd_addr_q;
  logic [IdW:0]         reset_val;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // Track which entries hold pushed data; the rest still hold their reset id.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // Reset contents: entry i holds ID_COUNT-1-i, so id 0 sits on top.
  assign reset_val = (IdW+1)'(ID_COUNT - 1) - (IdW+1)'(rd_addr_q);
  assign rd_data_o = rd_written_q ? rd_data_q : reset_val[IdW-1:0];

endmodule
`default_nettype wire

>>> rtl/id_allocator_free_stack_unit.sv
// Identifier allocator: hands out ids 0..ID_COUNT-1 from a last-in-first-out
// free stack and takes them back, checking a taken bitmap. Each request on the
// slave stream gives exactly one result on the master stream: an allocate
// returns success and the popped id (the first ones after reset are 0, 1, 2, ...),
// or success 0 with id 0 when the pool is empty; a free returns success 1 only
// if the id is below ID_COUNT and currently taken, and always id 0. A request
// first reads the stack top from the synchronous stack memory, then writes back
// and loads the result register. A stalled result holds the block only when a
// finished request finds the result register still full. No clearing pass is
// needed after reset; requests are taken from the first cycle.
`default_nettype none
`include "id_allocator_free_stack_unit_defines.svh"
module id_allocator_free_stack_unit
  import idalloc_pkg::*;
#(
  parameter int unsigned ID_COUNT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [0] operation, [8:1] request_id
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [0] success, [8:1] granted_id
);

  localparam int unsigned IdxW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned CntW = $clog2(ID_COUNT + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(ID_COUNT);
  localparam logic [IdW:0]    IdLimit = (IdW+1)'(ID_COUNT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic                state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ID_COUNT-1:0] taken_q;
  logic                op_q;
  id_t                 rid_q;
  logic                m_valid_q;
  logic [15:0]         m_data_q;

  logic                accept;
  logic                commit;
  logic [CntW-1:0]     cnt_dec;
  id_t                 top_id;
  logic                rid_ok;
  logic                alloc_ok;
  logic                free_ok;
  logic [IdxW-1:0]     rid_idx;
  logic [IdxW-1:0]     gid_idx;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_dec         = cnt_q - 1'b1;

  idalloc_stack_mem #(
    .ID_COUNT (ID_COUNT)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (cnt_dec[IdxW-1:0]),
    .rd_data_o (top_id),
    .wr_en_i   (commit && free_ok),
    .wr_addr_i (cnt_q[IdxW-1:0]),
    .wr_data_i (rid_q)
  );

  assign rid_idx  = rid_q[IdxW-1:0];
  assign gid_idx  = top_id[IdxW-1:0];
  assign rid_ok   = {1'b0, rid_q} < IdLimit;
  assign alloc_ok = (op_q == OP_ALLOC) && (cnt_q != '0);
  assign free_ok  = (op_q == OP_FREE) && rid_ok && taken_q[rid_idx] && (cnt_q != CntFull);
  // Finish only when the result register is free or draining this cycle.
  assign commit   = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (commit) begin
          state_d = ST_IDLE;
          if (alloc_ok) begin
            cnt_d = cnt_dec;
          end else if (free_ok) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= CntFull;
      taken_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (commit && alloc_ok) begin
        taken_q[gid_idx] <= 1'b1;
      end else if (commit && free_ok) begin
        taken_q[rid_idx] <= 1'b0;
      end
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tdata_i[0];
      rid_q <= s_axis_tdata_i[IdW:1];
    end
    if (commit) begin
      m_data_q <= {7'b0, (alloc_ok ? top_id : id_t'(0)), (alloc_ok || free_ok)};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `IDALLOC_ASSERT(a_cnt_range, cnt_q <= CntFull, "free count above pool size")
  `IDALLOC_ASSERT(a_pool_sum, ($countones(taken_q) + cnt_q) == ID_COUNT, "pool count mismatch")
  `IDALLOC_ASSERT(a_grant_taken, commit && alloc_ok |=> taken_q[$past(gid_idx)], "id not taken")
  `IDALLOC_ASSERT(a_alloc_pop, commit && alloc_ok |=> cnt_q == $past(cnt_dec), "pop missed")
  `IDALLOC_ASSERT(a_one_result, commit |=> m_valid_q && (state_q == ST_IDLE), "no result")

endmodule
`default_nettype wire
